>>> rtl/blaf_pkg.sv
// Shared types and constants for the beam local axes frame block.
// Used by the top level.
package blaf_pkg;

  localparam int AXIS_W = 32;
  localparam int COORD_IN_W = 32;
  localparam int LEN_W = 33;
  localparam int EPS_W = 31;

  localparam logic [EPS_W-1:0] EPS_RESET = 31'd1074;
  localparam logic [LEN_W-1:0] LEN_MAX = 33'h1_FFFF_FFFF;

  typedef logic [EPS_W-1:0] eps_t;

  typedef struct packed {
    logic signed [COORD_IN_W-1:0] start_x;
    logic signed [COORD_IN_W-1:0] start_y;
    logic signed [COORD_IN_W-1:0] start_z;
    logic signed [COORD_IN_W-1:0] end_x;
    logic signed [COORD_IN_W-1:0] end_y;
    logic signed [COORD_IN_W-1:0] end_z;
  } in_item_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] axis_x_0;
    logic signed [AXIS_W-1:0] axis_x_1;
    logic signed [AXIS_W-1:0] axis_x_2;
    logic signed [AXIS_W-1:0] axis_y_0;
    logic signed [AXIS_W-1:0] axis_y_1;
    logic signed [AXIS_W-1:0] axis_y_2;
    logic signed [AXIS_W-1:0] axis_z_0;
    logic signed [AXIS_W-1:0] axis_z_1;
    logic signed [AXIS_W-1:0] axis_z_2;
    logic [LEN_W-1:0]         element_length;
    logic                     vertical_case;
    logic                     degenerate;
  } out_item_t;

endpackage

>>> rtl/blaf_chan_if.sv
// Valid/ready channel carrying one payload of type T per transaction.
// Payload types come from blaf_pkg.
interface blaf_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/blaf_isqrt.sv
// Pipelined integer square root, one root bit per register stage.
// Carries a sideband vector alongside; no package dependencies.
module blaf_isqrt #(
  parameter int RW    = 33,
  parameter int SIDEW = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [2*RW-1:0]   in_rad,
  input  logic [SIDEW-1:0]  in_side,
  output logic              out_valid,
  output logic [RW-1:0]     out_root,
  output logic [SIDEW-1:0]  out_side
);

  localparam int SQ = 2 * RW;

  logic              val_r  [RW];
  logic [RW:0]       rem_r  [RW];
  logic [RW-1:0]     root_r [RW];
  logic [SQ-1:0]     rad_r  [RW];
  logic [SIDEW-1:0]  side_r [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic             v_i;
    logic [RW:0]      rem_i;
    logic [RW-1:0]    root_i;
    logic [SQ-1:0]    rad_i;
    logic [SIDEW-1:0] side_i;
    logic [RW+1:0]    rem_sh;
    logic [RW+1:0]    trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign v_i    = in_valid;
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = in_rad;
      assign side_i = in_side;
    end else begin : g_next
      assign v_i    = val_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign rad_i  = rad_r[k-1];
      assign side_i = side_r[k-1];
    end

    // Bring down the next two radicand bits and try root*4+1.
    assign rem_sh = {rem_i[RW-1:0], rad_i[SQ-1 -: 2]};
    assign trial  = {root_i, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        val_r[k] <= 1'b0;
      end else if (en) begin
        val_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? (RW+1)'(rem_sh - trial) : rem_sh[RW:0];
        root_r[k] <= {root_i[RW-2:0], ge};
        rad_r[k]  <= {rad_i[SQ-3:0], 2'b00};
        side_r[k] <= side_i;
      end
    end
  end

  assign out_valid = val_r[RW-1];
  assign out_root  = root_r[RW-1];
  assign out_side  = side_r[RW-1];

endmodule

>>> rtl/blaf_div.sv
// Pipelined restoring divider, three lanes sharing one divisor, one
// quotient bit per register stage. No package dependencies.
module blaf_div #(
  parameter int NW    = 61,
  parameter int DENW  = 33,
  parameter int QW    = 31,
  parameter int SIDEW = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NW-1:0]     in_num [3],
  input  logic [DENW-1:0]   in_den,
  input  logic [SIDEW-1:0]  in_side,
  output logic              out_valid,
  output logic [QW-1:0]     out_quo [3],
  output logic [DENW-1:0]   out_den,
  output logic [SIDEW-1:0]  out_side
);

  logic              val_r  [QW];
  logic [DENW-1:0]   rem_r  [QW][3];
  logic [QW-1:0]     nb_r   [QW][3];
  logic [QW-1:0]     q_r    [QW][3];
  logic [DENW-1:0]   den_r  [QW];
  logic [SIDEW-1:0]  side_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic             v_i;
    logic [DENW-1:0]  den_i;
    logic [SIDEW-1:0] side_i;

    if (k == 0) begin : g_first
      assign v_i    = in_valid;
      assign den_i  = in_den;
      assign side_i = in_side;
    end else begin : g_next
      assign v_i    = val_r[k-1];
      assign den_i  = den_r[k-1];
      assign side_i = side_r[k-1];
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [DENW-1:0] rem_i;
      logic [QW-1:0]   nb_i;
      logic [QW-1:0]   q_i;
      logic [DENW:0]   rem_sh;
      logic            ge;

      if (k == 0) begin : g_first
        // The high part of the numerator is below the divisor by construction.
        assign rem_i = DENW'(in_num[l][NW-1:QW]);
        assign nb_i  = in_num[l][QW-1:0];
        assign q_i   = '0;
      end else begin : g_next
        assign rem_i = rem_r[k-1][l];
        assign nb_i  = nb_r[k-1][l];
        assign q_i   = q_r[k-1][l];
      end

      assign rem_sh = {rem_i, nb_i[QW-1]};
      assign ge     = rem_sh >= {1'b0, den_i};

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k][l] <= ge ? DENW'(rem_sh - {1'b0, den_i}) : rem_sh[DENW-1:0];
          nb_r[k][l]  <= {nb_i[QW-2:0], 1'b0};
          q_r[k][l]   <= {q_i[QW-2:0], ge};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        val_r[k] <= 1'b0;
      end else if (en) begin
        val_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k]  <= den_i;
        side_r[k] <= side_i;
      end
    end
  end

  assign out_valid = val_r[QW-1];
  assign out_den   = den_r[QW-1];
  assign out_side  = side_r[QW-1];
  for (genvar l = 0; l < 3; l++) begin : g_out
    assign out_quo[l] = q_r[QW-1][l];
  end

endmodule

>>> rtl/blaf_norm.sv
// Vector normalizer: squares, sum, pipelined square root and three
// pipelined divisions with rounding. Uses blaf_isqrt and blaf_div.
module blaf_norm #(
  parameter int VW    = 32,
  parameter int F     = 30,
  parameter int SIDEW = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [VW:0]  in_comp [3],
  input  logic [SIDEW-1:0]    in_side,
  output logic                out_valid,
  output logic signed [F+1:0] out_comp [3],
  output logic [VW:0]         out_len,
  output logic [SIDEW-1:0]    out_side
);

  localparam int RW  = VW + 1;
  localparam int SQW = 2 * RW;
  localparam int NW  = VW + F + 1;
  localparam int QW  = F + 1;
  localparam int IS_SIDEW = 3 * VW + 3 + SIDEW;
  localparam int DV_SIDEW = 3 + SIDEW;

  // Stage A: magnitudes and signs.
  logic             va_r;
  logic [VW-1:0]    mag_a_r [3];
  logic [2:0]       sgn_a_r;
  logic [SIDEW-1:0] side_a_r;
  // Stage B: squares.
  logic             vb_r;
  logic [2*VW-1:0]  sq_b_r  [3];
  logic [VW-1:0]    mag_b_r [3];
  logic [2:0]       sgn_b_r;
  logic [SIDEW-1:0] side_b_r;
  // Stage C: sum of squares.
  logic             vc_r;
  logic [SQW-1:0]   sum_c_r;
  logic [IS_SIDEW-1:0] side_c_r;

  logic                is_valid;
  logic [RW-1:0]       is_root;
  logic [IS_SIDEW-1:0] is_side;
  logic [VW-1:0]       is_mag [3];
  logic [2:0]          is_sgn;
  logic [SIDEW-1:0]    is_rest;

  // Stage D: numerators.
  logic                vd_r;
  logic [NW-1:0]       num_d_r [3];
  logic [RW-1:0]       den_d_r;
  logic [DV_SIDEW-1:0] side_d_r;

  logic                dv_valid;
  logic [QW-1:0]       dv_quo [3];
  logic [RW-1:0]       dv_den;
  logic [DV_SIDEW-1:0] dv_side;

  logic                ve_r;
  logic signed [F+1:0] comp_e_r [3];
  logic [RW-1:0]       len_e_r;
  logic [SIDEW-1:0]    side_e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= is_valid;
      ve_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag_a_r[i] <= in_comp[i][VW] ? VW'(-in_comp[i]) : VW'(in_comp[i]);
        sgn_a_r[i] <= in_comp[i][VW];
        sq_b_r[i]  <= (2*VW)'(mag_a_r[i]) * (2*VW)'(mag_a_r[i]);
        mag_b_r[i] <= mag_a_r[i];
      end
      side_a_r <= in_side;
      sgn_b_r  <= sgn_a_r;
      side_b_r <= side_a_r;
      sum_c_r  <= SQW'(sq_b_r[0]) + SQW'(sq_b_r[1]) + SQW'(sq_b_r[2]);
      side_c_r <= {mag_b_r[0], mag_b_r[1], mag_b_r[2], sgn_b_r, side_b_r};
    end
  end

  blaf_isqrt #(.RW(RW), .SIDEW(IS_SIDEW)) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vc_r),
    .in_rad    (sum_c_r),
    .in_side   (side_c_r),
    .out_valid (is_valid),
    .out_root  (is_root),
    .out_side  (is_side)
  );

  assign {is_mag[0], is_mag[1], is_mag[2], is_sgn, is_rest} = is_side;

  // Adding half the length rounds the quotient to nearest.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num_d_r[i] <= (NW'(is_mag[i]) << F) + NW'(is_root >> 1);
      end
      den_d_r  <= is_root;
      side_d_r <= {is_sgn, is_rest};
    end
  end

  blaf_div #(.NW(NW), .DENW(RW), .QW(QW), .SIDEW(DV_SIDEW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vd_r),
    .in_num    (num_d_r),
    .in_den    (den_d_r),
    .in_side   (side_d_r),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_den   (dv_den),
    .out_side  (dv_side)
  );

  // A zero-length vector normalizes to zero.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_den == '0) begin
          comp_e_r[i] <= '0;
        end else if (dv_side[SIDEW+i]) begin
          comp_e_r[i] <= -$signed({1'b0, dv_quo[i]});
        end else begin
          comp_e_r[i] <= $signed({1'b0, dv_quo[i]});
        end
      end
      len_e_r  <= dv_den;
      side_e_r <= dv_side[SIDEW-1:0];
    end
  end

  assign out_valid = ve_r;
  assign out_comp  = comp_e_r;
  assign out_len   = len_e_r;
  assign out_side  = side_e_r;

endmodule

>>> rtl/blaf_cross.sv
// Three-stage cross product with each component rounded half away from
// zero to the unit scale. No package dependencies.
module blaf_cross #(
  parameter int F     = 30,
  parameter int SIDEW = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [F+1:0] in_a [3],
  input  logic signed [F+1:0] in_b [3],
  input  logic [SIDEW-1:0]    in_side,
  output logic                out_valid,
  output logic signed [F+2:0] out_c [3],
  output logic [SIDEW-1:0]    out_side
);

  localparam int PW = 2 * F + 4;
  localparam int TW = PW + 1;
  localparam int RW = TW - F;

  logic                v1_r, v2_r, v3_r;
  logic signed [PW-1:0] p_r [6];
  logic signed [TW-1:0] t_r [3];
  logic signed [F+2:0]  c_r [3];
  logic [SIDEW-1:0]     s1_r, s2_r, s3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= PW'(in_a[1] * in_b[2]);
      p_r[1] <= PW'(in_a[2] * in_b[1]);
      p_r[2] <= PW'(in_a[2] * in_b[0]);
      p_r[3] <= PW'(in_a[0] * in_b[2]);
      p_r[4] <= PW'(in_a[0] * in_b[1]);
      p_r[5] <= PW'(in_a[1] * in_b[0]);
      s1_r   <= in_side;
      for (int i = 0; i < 3; i++) begin
        t_r[i] <= TW'(p_r[2*i]) - TW'(p_r[2*i+1]);
      end
      s2_r <= s1_r;
      s3_r <= s2_r;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_round
    logic [TW-1:0] mag;
    logic [RW-1:0] rnd;
    assign mag = t_r[i][TW-1] ? TW'(-t_r[i]) : TW'(t_r[i]);
    assign rnd = RW'((mag + (TW'(1) << (F - 1))) >> F);
    always_ff @(posedge clk) begin
      if (en) begin
        c_r[i] <= t_r[i][TW-1] ? (F+3)'(-$signed({1'b0, rnd}))
                               : (F+3)'($signed({1'b0, rnd}));
      end
    end
  end

  assign out_valid = v3_r;
  assign out_c     = c_r;
  assign out_side  = s3_r;

endmodule

>>> rtl/beam_local_axes_frame.sv
// Beam element local axes: top level with channel handling and the
// epsilon register. Uses blaf_pkg, blaf_chan_if, blaf_norm and blaf_cross.
//
// Usage: each in_ch transaction carries the two end nodes of one line
// element; each out_ch transaction carries its local x, y and z unit axes,
// the element length and the vertical and degenerate flags. cfg_ch writes
// the epsilon tolerance of the vertical test; it is always ready. It must be
// written only while the block is idle; the block itself does not enforce this.
// The pipeline has one input stage, three normalizers of (vector width + 1)
// square root stages plus (UNIT_FRAC_BITS + 1) divide stages plus five each,
// a three-stage cross product, a vertical test stage and the output register.
// Throughput is one transaction per cycle while the receiver does not stall;
// the bit-serial root and divide pipelines set the depth, not the rate.
// Reset clears every valid bit and loads epsilon with its default of 1074.
// When the receiver stalls, the whole pipeline holds and in_ch.ready drops;
// nothing is lost or repeated.
module beam_local_axes_frame #(
  parameter int COORD_WIDTH    = 32,
  parameter int UNIT_FRAC_BITS = 30
) (
  input  logic         clk,
  input  logic         rst_n,
  blaf_chan_if.sink    in_ch,
  blaf_chan_if.source  out_ch,
  blaf_chan_if.sink    cfg_ch
);

  import blaf_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int F   = UNIT_FRAC_BITS;
  localparam int LW  = CW + 1;
  localparam int EW  = (F + 1 > EPS_W) ? F + 1 : EPS_W;
  localparam int LCW = (LW > LEN_W) ? LW : LEN_W;
  localparam int S2W = 3 * (F + 2) + LW + 2;
  localparam logic signed [F+1:0] ONE_UNIT = {2'b01, {F{1'b0}}};

  logic adv;
  eps_t eps_r;

  assign adv          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready  = adv;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_RESET;
    end else if (cfg_ch.valid) begin
      eps_r <= cfg_ch.data;
    end
  end

  // Input stage: node differences.
  logic signed [CW-1:0] cs [3];
  logic signed [CW-1:0] ce [3];
  logic signed [CW:0]   d_nxt [3];
  logic signed [CW:0]   d_r [3];
  logic                 v0_r;
  logic                 degen_nxt, degen0_r;

  assign cs[0] = CW'($unsigned(in_ch.data.start_x));
  assign cs[1] = CW'($unsigned(in_ch.data.start_y));
  assign cs[2] = CW'($unsigned(in_ch.data.start_z));
  assign ce[0] = CW'($unsigned(in_ch.data.end_x));
  assign ce[1] = CW'($unsigned(in_ch.data.end_y));
  assign ce[2] = CW'($unsigned(in_ch.data.end_z));

  for (genvar i = 0; i < 3; i++) begin : g_diff
    assign d_nxt[i] = $signed({ce[i][CW-1], ce[i]}) - $signed({cs[i][CW-1], cs[i]});
  end
  assign degen_nxt = (d_nxt[0] == '0) && (d_nxt[1] == '0) && (d_nxt[2] == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r      <= d_nxt;
      degen0_r <= degen_nxt;
    end
  end

  // Local x axis and element length.
  logic                n1_valid;
  logic signed [F+1:0] vx_n [3];
  logic [LW-1:0]       len_n;
  logic                n1_degen;

  blaf_norm #(.VW(CW), .F(F), .SIDEW(1)) u_norm_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (v0_r),
    .in_comp   (d_r),
    .in_side   (degen0_r),
    .out_valid (n1_valid),
    .out_comp  (vx_n),
    .out_len   (len_n),
    .out_side  (n1_degen)
  );

  // Vertical test; the y-axis candidate is global z cross x, which is
  // exactly (-x1, x0, 0).
  logic                vt_r;
  logic signed [F+1:0] vx_t_r [3];
  logic signed [F+1:0] zx_t_r [3];
  logic [LW-1:0]       len_t_r;
  logic                degen_t_r;
  logic                vert_t_r;
  logic [EW-1:0]       mag_x [3];
  logic [EW-1:0]       eps_e;
  logic                vert_nxt;

  for (genvar i = 0; i < 3; i++) begin : g_mag
    assign mag_x[i] = vx_n[i][F+1] ? EW'(-vx_n[i]) : EW'(vx_n[i]);
  end
  assign eps_e    = EW'(eps_r);
  assign vert_nxt = (mag_x[0] < eps_e) && (mag_x[1] < eps_e) && (mag_x[2] > eps_e);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vt_r <= 1'b0;
    end else if (adv) begin
      vt_r <= n1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vx_t_r    <= vx_n;
      zx_t_r[0] <= -vx_n[1];
      zx_t_r[1] <= vx_n[0];
      zx_t_r[2] <= '0;
      len_t_r   <= len_n;
      degen_t_r <= n1_degen;
      vert_t_r  <= vert_nxt;
    end
  end

  // Local y axis.
  logic                n2_valid;
  logic signed [F+1:0] vy_n [3];
  logic [F+1:0]        n2_len;
  logic [S2W-1:0]      n2_side;
  logic signed [F+1:0] vx2 [3];
  logic [LW-1:0]       len2;
  logic                degen2, vert2;
  logic signed [F+1:0] vy_sel [3];

  blaf_norm #(.VW(F + 1), .F(F), .SIDEW(S2W)) u_norm_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (vt_r),
    .in_comp   (zx_t_r),
    .in_side   ({vx_t_r[0], vx_t_r[1], vx_t_r[2], len_t_r, degen_t_r, vert_t_r}),
    .out_valid (n2_valid),
    .out_comp  (vy_n),
    .out_len   (n2_len),
    .out_side  (n2_side)
  );

  assign {vx2[0], vx2[1], vx2[2], len2, degen2, vert2} = n2_side;

  // The vertical rule replaces y by the global y axis; a zero length for
  // the y candidate already yields a zero vector.
  assign vy_sel[0] = (vert2 || n2_len == '0) ? '0 : vy_n[0];
  assign vy_sel[1] = vert2 ? ONE_UNIT : vy_n[1];
  assign vy_sel[2] = vert2 ? '0 : vy_n[2];

  // Local z axis: normalized x cross y.
  localparam int S3W = 6 * (F + 2) + LW + 2;

  logic                cr_valid;
  logic signed [F+2:0] cr_c [3];
  logic [S3W-1:0]      cr_side;
  logic                n3_valid;
  logic signed [F+1:0] vz_n [3];
  logic [F+2:0]        n3_len;
  logic [S3W-1:0]      n3_side;
  logic signed [F+1:0] vx3 [3];
  logic signed [F+1:0] vy3 [3];
  logic [LW-1:0]       len3;
  logic                degen3, vert3;

  blaf_cross #(.F(F), .SIDEW(S3W)) u_cross (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (n2_valid),
    .in_a      (vx2),
    .in_b      (vy_sel),
    .in_side   ({vx2[0], vx2[1], vx2[2], vy_sel[0], vy_sel[1], vy_sel[2],
                 len2, degen2, vert2}),
    .out_valid (cr_valid),
    .out_c     (cr_c),
    .out_side  (cr_side)
  );

  blaf_norm #(.VW(F + 2), .F(F), .SIDEW(S3W)) u_norm_z (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (cr_valid),
    .in_comp   (cr_c),
    .in_side   (cr_side),
    .out_valid (n3_valid),
    .out_comp  (vz_n),
    .out_len   (n3_len),
    .out_side  (n3_side)
  );

  assign {vx3[0], vx3[1], vx3[2], vy3[0], vy3[1], vy3[2], len3, degen3, vert3} = n3_side;

  // Output register; the z normalizer already forces a zero vector when
  // the cross product vanishes.
  logic            out_valid_r;
  out_item_t       out_data_r;
  out_item_t       out_data_nxt;
  logic [LCW-1:0]  len_w;
  logic [2:0]      vz_zero;

  assign len_w = LCW'(len3);
  for (genvar i = 0; i < 3; i++) begin : g_vz
    assign vz_zero[i] = (n3_len == '0) || (vz_n[i] == '0);
  end

  always_comb begin
    out_data_nxt.axis_x_0 = AXIS_W'(vx3[0]);
    out_data_nxt.axis_x_1 = AXIS_W'(vx3[1]);
    out_data_nxt.axis_x_2 = AXIS_W'(vx3[2]);
    out_data_nxt.axis_y_0 = AXIS_W'(vy3[0]);
    out_data_nxt.axis_y_1 = AXIS_W'(vy3[1]);
    out_data_nxt.axis_y_2 = AXIS_W'(vy3[2]);
    out_data_nxt.axis_z_0 = vz_zero[0] ? '0 : AXIS_W'(vz_n[0]);
    out_data_nxt.axis_z_1 = vz_zero[1] ? '0 : AXIS_W'(vz_n[1]);
    out_data_nxt.axis_z_2 = vz_zero[2] ? '0 : AXIS_W'(vz_n[2]);
    out_data_nxt.element_length = (len_w > LCW'(LEN_MAX)) ? LEN_MAX : LEN_W'(len_w);
    out_data_nxt.vertical_case  = vert3;
    out_data_nxt.degenerate     = degen3;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= n3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule
